[rtl/core/euler_pose_to_homogeneous_matrix_assert.svh]
// Assertion macros for the pose-to-transform block.
`ifndef EULER_POSE_TO_HOMOGENEOUS_MATRIX_ASSERT_SVH
`define EULER_POSE_TO_HOMOGENEOUS_MATRIX_ASSERT_SVH
// Checks that a consequent holds in the cycle after an antecedent.
`define EPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Checks that a condition holds in the same cycle.
`define EPH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

[rtl/core/eph_pkg.sv]
// ----------------------------------------------------------------------------
// eph_pkg
// Shared constants and helpers for the pose-to-transform pipeline.
// ----------------------------------------------------------------------------
package eph_pkg;
   localparam int TableLen = 24;
   localparam logic signed [33:0] CordicX0 = 34'sd652032874;
   localparam logic signed [15:0] QOne = 16'sd16384;

   function automatic logic signed [33:0] atan_entry(input int idx);
      logic signed [33:0] r;
      case (idx)
         0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
         3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
         6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
         9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
         12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
         15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
         18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
         21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

   // Clamps a wide signed value to plus or minus one in Q2.14.
   function automatic logic signed [15:0] clamp_one(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd16384) r = QOne;
      else if (v < -48'sd16384) r = -QOne;
      else r = v[15:0];
      return r;
   endfunction
endpackage

[rtl/core/euler_pose_to_homogeneous_matrix.sv]
// ----------------------------------------------------------------------------
// euler_pose_to_homogeneous_matrix
// Pose (translation plus ZYX Euler angles) to the top three rows of [R | t].
// ----------------------------------------------------------------------------
// An accepted req beat passes fold, CORDIC, round, prod2, prod3 and output registers to its rsp beat.
// Throughput: one beat per cycle; the whole pipeline advances when the
// output register is empty or being taken, and freezes while rsp_valid is held under rsp_stall.
// Reset clears all valid bits; payload registers are not reset.
`include "euler_pose_to_homogeneous_matrix_assert.svh"
module euler_pose_to_homogeneous_matrix #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_angle_roll,
   input  logic signed [15:0] req_angle_pitch,
   input  logic signed [15:0] req_angle_yaw,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic signed [31:0] rsp_t_x,
   output logic signed [31:0] rsp_t_y,
   output logic signed [31:0] rsp_t_z
);
   localparam int NS = (CORDIC_STAGES < eph_pkg::TableLen) ? CORDIC_STAGES
                                                            : eph_pkg::TableLen;
   // Stage 0 folds, stages 1..NS are CORDIC, then round, prod2, prod3, output.
   localparam int NP = NS + 4;

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic [NP:0]        vld_ff;
   logic signed [33:0] cx_ff [0:NS][0:2];
   logic signed [33:0] cy_ff [0:NS][0:2];
   logic signed [33:0] cz_ff [0:NS][0:2];
   logic [2:0]         neg_ff [0:NS];
   logic signed [31:0] tr_ff [0:NP][0:2];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NP-1:0], req_valid};
   end

   // Fold angles into [-pi/2, pi/2) and load the CORDIC.
   logic signed [15:0] ang [0:2];
   assign ang[0] = req_angle_roll;
   assign ang[1] = req_angle_pitch;
   assign ang[2] = req_angle_yaw;

   for (genvar a = 0; a < 3; a++) begin : g_ang
      logic signed [15:0] fold;
      logic               neg;
      always_comb begin
         fold = ang[a];
         neg  = 1'b0;
         if (ang[a] >= 16'sd16384) begin
            fold = ang[a] - 16'sd32767 - 16'sd1;
            neg  = 1'b1;
         end else if (ang[a] < -16'sd16384) begin
            fold = ang[a] + 16'sd32767 + 16'sd1;
            neg  = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[0][a] <= eph_pkg::CordicX0;
            cy_ff[0][a] <= '0;
            cz_ff[0][a] <= {{2{fold[15]}}, fold, 16'd0};
            neg_ff[0][a] <= neg;
         end
      end
      for (genvar s = 0; s < NS; s++) begin : g_stage
         logic signed [33:0] xs, ys, at;
         assign xs = cx_ff[s][a] >>> s;
         assign ys = cy_ff[s][a] >>> s;
         assign at = eph_pkg::atan_entry(s);
         always_ff @(posedge clock) begin
            if (adv) begin
               neg_ff[s+1][a] <= neg_ff[s][a];
               if (!cz_ff[s][a][33]) begin
                  cx_ff[s+1][a] <= cx_ff[s][a] - ys;
                  cy_ff[s+1][a] <= cy_ff[s][a] + xs;
                  cz_ff[s+1][a] <= cz_ff[s][a] - at;
               end else begin
                  cx_ff[s+1][a] <= cx_ff[s][a] + ys;
                  cy_ff[s+1][a] <= cy_ff[s][a] - xs;
                  cz_ff[s+1][a] <= cz_ff[s][a] + at;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tr_ff[0][0] <= req_pos_x;
         tr_ff[0][1] <= req_pos_y;
         tr_ff[0][2] <= req_pos_z;
         for (int s = 0; s < NP; s++) tr_ff[s+1] <= tr_ff[s];
      end
   end

   // Round to Q2.14, clamp, apply the fold negation.
   logic signed [15:0] sn_ff [0:2];
   logic signed [15:0] cs_ff [0:2];
   for (genvar a = 0; a < 3; a++) begin : g_rnd
      logic signed [33:0] xr, yr;
      logic signed [15:0] xc, yc;
      assign xr = (cx_ff[NS][a] + 34'sd32768) >>> 16;
      assign yr = (cy_ff[NS][a] + 34'sd32768) >>> 16;
      assign xc = eph_pkg::clamp_one(48'(xr));
      assign yc = eph_pkg::clamp_one(48'(yr));
      always_ff @(posedge clock) begin
         if (adv) begin
            cs_ff[a] <= neg_ff[NS][a] ? -xc : xc;
            sn_ff[a] <= neg_ff[NS][a] ? -yc : yc;
         end
      end
   end

   // Two-factor products, kept exact, plus delayed operands.
   logic signed [31:0] p_cycp_ff, p_sycp_ff, p_cpsr_ff, p_cpcr_ff;
   logic signed [31:0] p_cysp_ff, p_sysp_ff, p_sycr_ff, p_sysr_ff, p_cycr_ff, p_cysr_ff;
   logic signed [15:0] d_sr_ff, d_cr_ff, d_sp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p_cycp_ff <= cs_ff[2] * cs_ff[1];
         p_sycp_ff <= sn_ff[2] * cs_ff[1];
         p_cpsr_ff <= cs_ff[1] * sn_ff[0];
         p_cpcr_ff <= cs_ff[1] * cs_ff[0];
         p_cysp_ff <= cs_ff[2] * sn_ff[1];
         p_sysp_ff <= sn_ff[2] * sn_ff[1];
         p_sycr_ff <= sn_ff[2] * cs_ff[0];
         p_sysr_ff <= sn_ff[2] * sn_ff[0];
         p_cycr_ff <= cs_ff[2] * cs_ff[0];
         p_cysr_ff <= cs_ff[2] * sn_ff[0];
         d_sr_ff <= sn_ff[0];
         d_cr_ff <= cs_ff[0];
         d_sp_ff <= sn_ff[1];
      end
   end

   // Three-factor products, shifted two-factor terms, the two-factor roundings and the negated sine for m20.
   logic signed [47:0] q01_ff, q02_ff, q11_ff, q12_ff;
   logic signed [47:0] e01_ff, e02_ff, e11_ff, e12_ff;
   logic signed [15:0] r00_ff, r10_ff, r21_ff, r22_ff, r20_ff;

   function automatic logic signed [15:0] rnd2(input logic signed [31:0] p);
      logic signed [47:0] t;
      t = (48'(p) + 48'sd8192) >>> 14;
      return eph_pkg::clamp_one(t);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         q01_ff <= 48'(p_cysp_ff) * 48'(d_sr_ff);
         q02_ff <= 48'(p_cysp_ff) * 48'(d_cr_ff);
         q11_ff <= 48'(p_sysp_ff) * 48'(d_sr_ff);
         q12_ff <= 48'(p_sysp_ff) * 48'(d_cr_ff);
         e01_ff <= -(48'(p_sycr_ff) <<< 14);
         e02_ff <= 48'(p_sysr_ff) <<< 14;
         e11_ff <= 48'(p_cycr_ff) <<< 14;
         e12_ff <= -(48'(p_cysr_ff) <<< 14);
         r00_ff <= rnd2(p_cycp_ff);
         r10_ff <= rnd2(p_sycp_ff);
         r21_ff <= rnd2(p_cpsr_ff);
         r22_ff <= rnd2(p_cpcr_ff);
         r20_ff <= -d_sp_ff;
      end
   end

   function automatic logic signed [15:0] rnd3(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
      logic signed [47:0] t;
      t = (a + b + 48'sd134217728) >>> 28;
      return eph_pkg::clamp_one(t);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_m00 <= r00_ff;
         rsp_m01 <= rnd3(q01_ff, e01_ff);
         rsp_m02 <= rnd3(q02_ff, e02_ff);
         rsp_m10 <= r10_ff;
         rsp_m11 <= rnd3(q11_ff, e11_ff);
         rsp_m12 <= rnd3(q12_ff, e12_ff);
         rsp_m20 <= r20_ff;
         rsp_m21 <= r21_ff;
         rsp_m22 <= r22_ff;
      end
   end

   assign rsp_valid = vld_ff[NP];
   assign rsp_t_x   = tr_ff[NP][0];
   assign rsp_t_y   = tr_ff[NP][1];
   assign rsp_t_z   = tr_ff[NP][2];

   `EPH_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_m11))
   `EPH_ASSERT_NOW(a_stall, clock, reset, req_stall, rsp_valid && rsp_stall)
   `EPH_ASSERT_NOW(a_range, clock, reset, rsp_valid,
      rsp_m00 <= 16'sd16384 && rsp_m00 >= -16'sd16384 && rsp_m20 >= -16'sd16384)
endmodule
